FILE: design/srcf_pkg.sv
// shared types, frame constants and the crc-8 byte update for the record framer
// no dependencies
package srcf_pkg;

  localparam int FRAME_BYTES   = 24;
  localparam int PAYLOAD_BYTES = 20;
  localparam int PAYLOAD_START = 3;
  localparam int CNT_W         = $clog2(FRAME_BYTES);
  localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;

  localparam logic [7:0] SYNC_A   = 8'h5A;
  localparam logic [7:0] SYNC_B   = 8'hA5;
  localparam logic [7:0] LEN_BYTE = 8'(PAYLOAD_BYTES);
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [CNT_W-1:0] POS_SYNC_A = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_SYNC_B = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_LEN    = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_CRC    = CNT_W'(FRAME_BYTES - 1);

  typedef struct packed {
    logic        [31:0] sensor_id;
    logic        [31:0] reading_kind;
    logic signed [31:0] reading_value;
    logic signed [63:0] time_ms;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } out_word_t;

  // msb-first crc-8, one byte folded in over eight shift steps
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: design/srcf_in_reg.sv
// input record register of the framer: holds one record until its frame is sent
// depends on srcf_pkg
module srcf_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  srcf_pkg::in_word_t in_data,
  input  logic              done,
  output logic              rec_valid,
  output srcf_pkg::in_word_t rec
);
  import srcf_pkg::*;

  // a new record may land in the same cycle the last byte of the old one enters the output register
  assign in_ready = !rec_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (in_ready) begin
      rec_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rec <= in_data;
    end
  end

endmodule

FILE: design/srcf_serializer.sv
// byte serializer: walks the frame positions, folds payload bytes into the crc
// and registers each byte for the output channel; depends on srcf_pkg
module srcf_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  input  srcf_pkg::in_word_t rec,
  output logic               done,
  output logic               out_valid,
  input  logic               out_ready,
  output srcf_pkg::out_word_t out_data
);
  import srcf_pkg::*;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;
  logic [CNT_W-1:0]     pidx;
  logic [7:0]           crc;
  logic [7:0]           crc_next;
  logic [7:0]           cur_byte;
  logic [7:0]           pay_byte;
  logic [PAYLOAD_W-1:0] payload;
  logic                 load;
  logic                 is_last;

  // little-endian: byte 0 of the payload is the low byte of sensor_id
  assign payload = {rec.time_ms, rec.reading_value, rec.reading_kind, rec.sensor_id};
  assign pidx    = cnt - CNT_W'(PAYLOAD_START);
  assign pay_byte = 8'(payload >> {pidx, 3'b000});
  assign is_last = (cnt == POS_CRC);

  always_comb begin
    case (cnt)
      POS_SYNC_A: cur_byte = SYNC_A;
      POS_SYNC_B: cur_byte = SYNC_B;
      POS_LEN:    cur_byte = LEN_BYTE;
      POS_CRC:    cur_byte = crc;
      default:    cur_byte = pay_byte;
    endcase
  end

  always_comb begin
    case (cnt)
      POS_SYNC_A, POS_SYNC_B, POS_LEN: crc_next = CRC_INIT;
      POS_CRC:                         crc_next = crc;
      default:                         crc_next = crc8_update(crc, pay_byte);
    endcase
  end

  assign cnt_next = is_last ? '0 : cnt + CNT_W'(1);
  assign load     = rec_valid && (!out_valid || out_ready);
  assign done     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        cnt <= cnt_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      crc                 <= crc_next;
      out_data.frame_byte <= cur_byte;
      out_data.last       <= is_last;
    end
  end

endmodule

FILE: design/sensor_record_crc8_framer.sv
// sensor record framer: turns each record into a 24-byte frame with crc-8
// top level; depends on srcf_pkg, srcf_in_reg and srcf_serializer
//
// input channel (in_valid/in_ready/in_data): one sensor record per word.
// output channel (out_valid/out_ready/out_data): one frame byte per word,
// 24 words per record: 0x5A, 0xA5, length 20, the 20 payload bytes
// (sensor id, kind, value, timestamp, each least significant byte first)
// and the crc-8 of the payload; last is set on the crc byte.
// a record is first taken into the input register, and the first byte of its
// frame is then loaded into the output register.
// throughput: one output byte per cycle while out_ready is high; the byte
// position counter of the serializer and the single output register set it.
// the next record is taken in the cycle the crc byte of the current one
// enters the output register, so frames follow with no gap.
// a stall on out_ready holds the current byte and freezes the counter and
// crc; in_ready stays low while a record is still being sent.
// reset empties both registers and returns the byte counter to the start
// of a frame; nothing else is kept between records.
module sensor_record_crc8_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srcf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srcf_pkg::out_word_t out_data
);
  import srcf_pkg::*;

  logic     rec_valid;
  logic     done;
  in_word_t rec;

  srcf_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .done      (done),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  srcf_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec       (rec),
    .done      (done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: dv/sensor_record_crc8_framer_tb.sv
// self-checking testbench for sensor_record_crc8_framer: random and directed records,
// 24-byte frames predicted in the bench and compared byte by byte with random stalls
// depends on srcf_pkg and sensor_record_crc8_framer
module sensor_record_crc8_framer_tb;
  import srcf_pkg::*;

  localparam int RANDOM_RECORDS = 470;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_AT        = 1500;
  localparam int HOLD_CYCLES    = 300;
  localparam int CALM_FROM      = 4000;
  localparam int CALM_TO        = 7000;
  localparam int IDLE_PCT       = 13;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  in_word_t  records_todo[$];
  out_word_t frame_bytes_due[$];
  out_word_t due_word;
  int        records_total = 0;
  int        records_taken = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  logic      calm;

  sensor_record_crc8_framer uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // window where neither side idles
  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       top;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      top = c[7];
      c   = c << 1;
      if (top) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // expected frame for one record: sync, length, little-endian payload, crc
  function automatic void queue_frame(input in_word_t rec);
    logic [PAYLOAD_W-1:0] payload;
    logic [7:0]           crc;
    logic [7:0]           b;
    payload = {rec.time_ms, rec.reading_value, rec.reading_kind, rec.sensor_id};
    crc = CRC_INIT;
    frame_bytes_due.push_back('{frame_byte: SYNC_A, last: 1'b0});
    frame_bytes_due.push_back('{frame_byte: SYNC_B, last: 1'b0});
    frame_bytes_due.push_back('{frame_byte: LEN_BYTE, last: 1'b0});
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      b = payload[8*i +: 8];
      frame_bytes_due.push_back('{frame_byte: b, last: 1'b0});
      crc = crc8_fold(crc, b);
    end
    frame_bytes_due.push_back('{frame_byte: crc, last: 1'b1});
  endfunction

  function automatic in_word_t make_record(input logic [31:0] id, input logic [31:0] kind,
                                           input logic [31:0] value, input logic [63:0] ms);
    in_word_t rec;
    rec.sensor_id     = id;
    rec.reading_kind  = kind;
    rec.reading_value = value;
    rec.time_ms       = ms;
    return rec;
  endfunction

  function automatic in_word_t random_record();
    in_word_t rec;
    int       mode;
    mode = $urandom_range(3);
    rec = make_record($urandom, $urandom, $urandom, {$urandom, $urandom});
    case (mode)
      1: begin
        // small ids and codes, plausible timestamps
        rec.sensor_id    = $urandom_range(15);
        rec.reading_kind = $urandom_range(7);
        rec.time_ms      = {32'h0000_0000, $urandom};
      end
      2: begin
        // negative readings and timestamps
        rec.reading_value = -$signed({1'b0, 31'($urandom_range(65535))});
        rec.time_ms       = -$signed({1'b0, 63'($urandom)});
      end
      3: begin
        // extremes mixed in per field
        if ($urandom_range(1)) rec.reading_value = {1'b1, 31'h0};
        else rec.reading_value = {1'b0, {31{1'b1}}};
        if ($urandom_range(1)) rec.time_ms = {1'b1, 63'h0};
        else rec.time_ms = {1'b0, {63{1'b1}}};
      end
      default: begin
      end
    endcase
    return rec;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // record driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        queue_frame(in_data);
        records_taken = records_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (records_todo.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= records_todo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off so the framer backs up into its input
  always @(posedge clk) begin
    if (cycle_count == HOLD_AT) begin
      stall_left <= HOLD_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // byte monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          $error("unexpected word: frame_byte %h last %b", out_data.frame_byte, out_data.last);
          error_count = error_count + 1;
        end else begin
          due_word = frame_bytes_due.pop_front();
          if (out_data.frame_byte !== due_word.frame_byte) begin
            $error("frame_byte mismatch: expected %h, actual %h",
                   due_word.frame_byte, out_data.frame_byte);
            error_count = error_count + 1;
          end
          if (out_data.last !== due_word.last) begin
            $error("last mismatch: expected %b, actual %b", due_word.last, out_data.last);
            error_count = error_count + 1;
          end
        end
      end
      out_ready <= (stall_left == 0) && (cycle_count != HOLD_AT)
                   && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    // directed records: extremes, bit patterns, sync and length values inside the payload
    records_todo.push_back(make_record(32'h0, 32'h0, 32'h0, 64'h0));
    records_todo.push_back(make_record('1, '1, '1, '1));
    records_todo.push_back(make_record(32'h0, 32'h1, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF));
    records_todo.push_back(make_record(32'h1, 32'h0, 32'h8000_0000, 64'h8000_0000_0000_0000));
    records_todo.push_back(make_record(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                       64'h5555_5555_5555_5555));
    records_todo.push_back(make_record(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                       64'hAAAA_AAAA_AAAA_AAAA));
    records_todo.push_back(make_record(32'hA55A_A55A, 32'h5AA5_5AA5, 32'h1414_1414,
                                       64'h5AA5_5AA5_5AA5_5AA5));
    records_todo.push_back(make_record(32'h7, 32'h3, 32'hFFFF_FFFE, 64'hFFFF_FFFF_FFFF_FC18));
    records_todo.push_back(make_record(32'h1, 32'h2, 32'h8000_0001, 64'h0000_0001_0000_0000));
    records_todo.push_back(make_record(32'h0000_002A, 32'h0000_0004, 32'h4000_0000,
                                       64'h0000_018B_CFE5_6800));
    records_todo.push_back(make_record(32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                                       64'h0000_0000_0000_0001));
    records_todo.push_back(make_record(32'h0000_00FF, 32'hFF00_0000, 32'h00FF_FF00,
                                       64'hFF00_0000_0000_00FF));
    for (int n = 0; n < RANDOM_RECORDS; n++) begin
      records_todo.push_back(random_record());
    end
    records_total = records_todo.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (records_taken != records_total) @(negedge clk);
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
design/srcf_pkg.sv
design/srcf_in_reg.sv
design/srcf_serializer.sv
design/sensor_record_crc8_framer.sv
dv/sensor_record_crc8_framer_tb.sv
